// ===== rtl/vsl_pkg.sv =====
// Shared types and constants of the slope limiter.
package vsl_pkg;
  localparam logic [15:0] ONE_Q15 = 16'd32768;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL,
    ST_SUM,
    ST_RDIV,
    ST_RWAIT,
    ST_POLY,
    ST_PDIV,
    ST_PWAIT,
    ST_STORE,
    ST_COUPLE,
    ST_EMUL,
    ST_EOUT
  } state_t;
endpackage

// ===== rtl/venkat_slope_limiter.sv =====
// Top level of the Venkatakrishnan slope limiter.
// One item per (variable, side) enters when in_stall is low and the block is
// idle. Each item multiplies gradient by offset on one shared 32x32 multiplier
// and sums the products, then runs up to two 64-bit divisions on one shared
// restoring divider, one quotient bit per cycle: the ratio r and the limiter
// quotient. At the cell's last item the momentum factors are capped by the
// depth factor when coupling is on, and one limited gradient per stored
// variable is emitted, each from the shared multiplier, then transferred.
// The factor and gradient stores hold no reset value; the feeder sends
// every variable of a cell.
module venkat_slope_limiter import vsl_pkg::*; #(
  parameter int NVARS = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         in_var_index,
  input  logic               in_side_last,
  input  logic               in_var_last,
  input  logic               in_has_neighbor,
  input  logic signed [31:0] in_cell_avg,
  input  logic signed [31:0] in_neighbor_avg,
  input  logic signed [31:0] in_grad_x,
  input  logic signed [31:0] in_grad_y,
  input  logic signed [31:0] in_grad_z,
  input  logic signed [31:0] in_offset_x,
  input  logic signed [31:0] in_offset_y,
  input  logic signed [31:0] in_offset_z,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_index,
  input  logic [31:0]        cfg_data,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         out_var,
  output logic signed [31:0] out_lim_grad_x,
  output logic signed [31:0] out_lim_grad_y,
  output logic signed [31:0] out_lim_grad_z,
  output logic [15:0]        out_limit_factor,
  output logic               out_last
);
  localparam int VW = (NVARS > 1) ? $clog2(NVARS) : 1;
  localparam int CW = $clog2(NVARS + 1);
  localparam int GW = $clog2(NVARS * 3);
  localparam logic CFG_BETA = 1'b0;
  localparam logic CFG_COUPLE = 1'b1;

  state_t state_r, state_nxt;
  logic [31:0] beta_r;
  logic        couple_r;
  logic [15:0] run_r, run_nxt;
  logic [CW-1:0] vcnt_r, vcnt_nxt;
  logic [15:0] fstore [NVARS];
  logic signed [31:0] gstore [NVARS*3];

  // latched item
  logic [2:0]  k_r;
  logic        sl_r, vl_r, nb_r;
  logic signed [31:0] u0_r, un_r;
  logic signed [31:0] g_r [3];
  logic signed [31:0] o_r [3];
  logic [1:0]  step_r, step_nxt;
  logic signed [49:0] du_r, du_nxt;
  logic signed [63:0] prod_r;
  logic        prod_v_r, prod_v_nxt;
  logic [CW-1:0] ev_r, ev_nxt;
  logic signed [31:0] lg_r [3];

  // shared multiplier
  logic signed [32:0] ma, mb;
  logic signed [65:0] mp;
  assign mp = ma * mb;

  // shared divider
  logic        d_start, d_busy;
  logic [63:0] d_num, d_den, d_quot;
  vsl_div #(.W(64)) u_div (
    .clk(clk), .rst_n(rst_n), .start(d_start), .num(d_num), .den(d_den),
    .busy(d_busy), .quot(d_quot)
  );

  logic [63:0] r_r;
  logic [63:0] n_r, dd_r;
  logic signed [33:0] bound;
  logic [49:0] absdu;
  logic        in_fire;
  logic [VW-1:0] kidx, eidx;
  logic [GW-1:0] gkidx, geidx;
  logic        k_ok;
  logic [15:0] phi;

  assign in_fire = in_valid && !in_stall;
  assign in_stall = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign kidx = VW'(k_r);
  assign k_ok = (5'(k_r) < 5'(NVARS));
  assign eidx = ev_r[VW-1:0];
  assign gkidx = GW'(3 * int'(kidx));
  assign geidx = GW'(3 * int'(eidx) + int'(step_r));
  assign absdu = du_r[49] ? 50'(-du_r) : 50'(du_r);

  always_comb begin
    logic signed [33:0] umax, umin;
    umax = 34'(u0_r);
    umin = 34'(u0_r);
    if (nb_r && un_r > u0_r) umax = 34'(un_r);
    if (nb_r && un_r < u0_r) umin = 34'(un_r);
    bound = du_r[49] ? (34'(u0_r) - umin) : (umax - 34'(u0_r));
  end

  always_comb begin
    phi = (d_quot > 64'(ONE_Q15)) ? ONE_Q15 : d_quot[15:0];
  end

  always_comb begin
    state_nxt = state_r;
    step_nxt = step_r;
    du_nxt = du_r;
    prod_v_nxt = 1'b0;
    run_nxt = run_r;
    vcnt_nxt = vcnt_r;
    ev_nxt = ev_r;
    d_start = 1'b0;
    d_num = '0;
    d_den = '0;
    ma = '0;
    mb = '0;
    out_valid = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          state_nxt = ST_MUL;
          step_nxt = '0;
          du_nxt = '0;
        end
      end
      ST_MUL: begin
        // one product per cycle, accumulate the floored previous product
        ma = 33'(g_r[step_r]);
        mb = 33'(o_r[step_r]);
        prod_v_nxt = 1'b1;
        if (prod_v_r) du_nxt = du_r + 50'(prod_r >>> 16);
        if (step_r == 2'd2) state_nxt = ST_SUM;
        else step_nxt = step_r + 2'd1;
      end
      ST_SUM: begin
        du_nxt = du_r + 50'(prod_r >>> 16);
        state_nxt = ST_RDIV;
      end
      ST_RDIV: begin
        if (du_r == '0) begin
          state_nxt = ST_STORE;
        end else begin
          d_start = 1'b1;
          d_num = 64'($unsigned(bound)) << 16;
          d_den = 64'(absdu);
          state_nxt = ST_RWAIT;
        end
      end
      ST_RWAIT: begin
        if (!d_busy) begin
          if (d_quot == '0) begin
            if (run_r != 16'd0) run_nxt = 16'd0;
            state_nxt = ST_STORE;
          end else if (d_quot >= 64'(2) << 16) begin
            state_nxt = ST_STORE;
          end else begin
            state_nxt = ST_POLY;
          end
        end
      end
      ST_POLY: begin
        // r^2 on the shared multiplier, r below two so 18 bits
        ma = 33'(r_r[17:0]);
        mb = 33'(r_r[17:0]);
        state_nxt = ST_PDIV;
      end
      ST_PDIV: begin
        d_start = 1'b1;
        d_num = n_r << 15;
        d_den = dd_r;
        state_nxt = ST_PWAIT;
      end
      ST_PWAIT: begin
        if (!d_busy) begin
          if (phi < run_r) run_nxt = phi;
          state_nxt = ST_STORE;
        end
      end
      ST_STORE: begin
        if (sl_r) begin
          if (k_ok && (CW'(k_r) + CW'(1)) > vcnt_r) vcnt_nxt = CW'(k_r) + CW'(1);
          run_nxt = ONE_Q15;
          if (vl_r) begin
            state_nxt = ST_COUPLE;
          end else begin
            state_nxt = ST_IDLE;
          end
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_COUPLE: begin
        ev_nxt = '0;
        step_nxt = '0;
        state_nxt = (vcnt_r == '0) ? ST_IDLE : ST_EMUL;
      end
      ST_EMUL: begin
        ma = 33'(gstore[geidx]);
        mb = 33'({1'b0, fstore[eidx]});
        if (step_r == 2'd2) state_nxt = ST_EOUT;
        else step_nxt = step_r + 2'd1;
      end
      ST_EOUT: begin
        out_valid = 1'b1;
        if (!out_stall) begin
          step_nxt = '0;
          if (ev_r + CW'(1) == vcnt_r) begin
            vcnt_nxt = '0;
            state_nxt = ST_IDLE;
          end else begin
            ev_nxt = ev_r + CW'(1);
            state_nxt = ST_EMUL;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      beta_r <= 32'd65536;
      couple_r <= 1'b1;
      run_r <= ONE_Q15;
      vcnt_r <= '0;
      prod_v_r <= 1'b0;
      ev_r <= '0;
      step_r <= '0;
    end else begin
      state_r <= state_nxt;
      run_r <= run_nxt;
      vcnt_r <= vcnt_nxt;
      prod_v_r <= prod_v_nxt;
      ev_r <= ev_nxt;
      step_r <= step_nxt;
      if (cfg_valid) begin
        case (cfg_index)
          CFG_BETA: beta_r <= cfg_data;
          CFG_COUPLE: couple_r <= cfg_data[0];
          default: ;
        endcase
      end
    end
  end

  // payload and stores
  always_ff @(posedge clk) begin
    du_r <= du_nxt;
    if (in_fire) begin
      k_r <= in_var_index;
      sl_r <= in_side_last;
      vl_r <= in_var_last;
      nb_r <= in_has_neighbor;
      u0_r <= in_cell_avg;
      un_r <= in_neighbor_avg;
      g_r[0] <= in_grad_x;
      g_r[1] <= in_grad_y;
      g_r[2] <= in_grad_z;
      o_r[0] <= in_offset_x;
      o_r[1] <= in_offset_y;
      o_r[2] <= in_offset_z;
    end
    if (state_r == ST_MUL) prod_r <= 64'(mp);
    if (state_r == ST_RWAIT && !d_busy) r_r <= d_quot;
    if (state_r == ST_POLY) begin
      n_r <= 64'(mp[35:0]) + (r_r << 17) + (64'(beta_r) << 16);
      dd_r <= 64'(mp[35:0]) + (r_r << 16) + (64'd2 << 32) + (64'(beta_r) << 16);
    end
    if (state_r == ST_STORE && sl_r && k_ok) begin
      fstore[kidx] <= run_r;
      gstore[gkidx]           <= g_r[0];
      gstore[gkidx + GW'(1)]  <= g_r[1];
      gstore[gkidx + GW'(2)]  <= g_r[2];
    end
    if (state_r == ST_COUPLE && couple_r && vcnt_r >= CW'(3) && NVARS >= 3) begin
      if (fstore[1] > fstore[0]) fstore[1] <= fstore[0];
      if (fstore[2 % NVARS] > fstore[0]) fstore[2 % NVARS] <= fstore[0];
    end
    if (state_r == ST_EMUL) lg_r[step_r] <= 32'(mp >>> 15);
  end

  assign out_var = 3'(ev_r);
  assign out_lim_grad_x = lg_r[0];
  assign out_lim_grad_y = lg_r[1];
  assign out_lim_grad_z = lg_r[2];
  assign out_limit_factor = fstore[eidx];
  assign out_last = (ev_r + CW'(1) == vcnt_r);
endmodule

// ===== rtl/vsl_div.sv =====
// Restoring divider, one quotient bit per cycle.
module vsl_div import vsl_pkg::*; #(
  parameter int W = 64
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [W-1:0] num,
  input  logic [W-1:0] den,
  output logic         busy,
  output logic [W-1:0] quot
);
  localparam int CW = $clog2(W + 1);
  logic [W-1:0] q_r, q_nxt;
  logic [W:0]   rem_r, rem_nxt;
  logic [W-1:0] den_r;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic         busy_r, busy_nxt;
  logic [W:0]   trial;

  always_comb begin
    q_nxt = q_r;
    rem_nxt = rem_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    trial = {rem_r[W-1:0], q_r[W-1]};
    if (start) begin
      q_nxt = num;
      rem_nxt = '0;
      cnt_nxt = CW'(W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, den_r}) begin
        rem_nxt = trial - {1'b0, den_r};
        q_nxt = {q_r[W-2:0], 1'b1};
      end else begin
        rem_nxt = trial;
        q_nxt = {q_r[W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r <= cnt_nxt;
    end
    q_r <= q_nxt;
    rem_r <= rem_nxt;
    if (start) den_r <= den;
  end

  assign busy = busy_r;
  assign quot = q_r;
endmodule

// ===== sim/tb_top.sv =====
// Self-checking testbench for the Venkatakrishnan slope limiter top level.
`timescale 1ns / 1ps

module tb_top;
  import vsl_pkg::*;

  localparam int NSLOT = 8;
  localparam int STALL_LIMIT = 20000;  // cycles without any transfer
  localparam int DRAIN_CYCLES = 300;
  localparam int HOLD_CYCLES = 4000;   // long receiver hold-off, longer than a cell

  // configuration register indexes
  localparam logic REG_BETA = 1'b0;
  localparam logic REG_COUPLE = 1'b1;

  typedef struct {
    logic [2:0]         k;
    logic               side_last;
    logic               var_last;
    logic               nb;
    logic signed [31:0] u0, un;
    logic signed [31:0] gx, gy, gz;
    logic signed [31:0] ox, oy, oz;
  } side_item_t;

  typedef struct {
    logic [2:0]         v;
    logic signed [31:0] x, y, z;
    logic [15:0]        f;
    logic               last;
  } lim_grad_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [2:0]         in_var_index = '0;
  logic               in_side_last = 1'b0;
  logic               in_var_last = 1'b0;
  logic               in_has_neighbor = 1'b0;
  logic signed [31:0] in_cell_avg = '0;
  logic signed [31:0] in_neighbor_avg = '0;
  logic signed [31:0] in_grad_x = '0;
  logic signed [31:0] in_grad_y = '0;
  logic signed [31:0] in_grad_z = '0;
  logic signed [31:0] in_offset_x = '0;
  logic signed [31:0] in_offset_y = '0;
  logic signed [31:0] in_offset_z = '0;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic               cfg_index = REG_BETA;
  logic [31:0]        cfg_data = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [2:0]         out_var;
  logic signed [31:0] out_lim_grad_x;
  logic signed [31:0] out_lim_grad_y;
  logic signed [31:0] out_lim_grad_z;
  logic [15:0]        out_limit_factor;
  logic               out_last;

  always #6 clk = ~clk;

  venkat_slope_limiter i_dut (.*);

  // ---------------------------------------------------------------------------
  // Limiter predictor: own copy of registers and per-cell state
  // ---------------------------------------------------------------------------
  logic [31:0]        beta_q = 32'd65536;
  logic               couple_q = 1'b1;
  logic [15:0]        run_phi = ONE_Q15;
  logic [15:0]        phi_slot [NSLOT];
  logic signed [31:0] grad_slot [NSLOT][3];
  int                 nstored = 0;

  side_item_t  pending_sides[$];
  lim_grad_t   expected_grads[$];

  int n_in = 0, n_out = 0, n_cells = 0, n_cfg = 0, n_err = 0;

  // phi of the Venkatakrishnan function for ratio r in unsigned Q16.16
  function automatic logic [15:0] venkat_phi(logic [63:0] r);
    logic [63:0] num, den, q;
    if (r == 0) return 16'd0;
    if (r >= 64'd131072) return ONE_Q15;
    num = r * r + (r << 17) + ({32'd0, beta_q} << 16);
    den = r * r + (r << 16) + (64'd2 << 32) + ({32'd0, beta_q} << 16);
    q = (num << 15) / den;
    return (q > ONE_Q15) ? ONE_Q15 : q[15:0];
  endfunction

  function automatic void predict_side(side_item_t it);
    longint du, umax, umin, bound, prod;
    logic [63:0] r;
    logic [15:0] phi;
    logic signed [31:0] g[3];
    logic signed [31:0] o[3];
    lim_grad_t res;
    g = '{it.gx, it.gy, it.gz};
    o = '{it.ox, it.oy, it.oz};
    du = 0;
    for (int i = 0; i < 3; i++) begin
      prod = longint'(g[i]) * longint'(o[i]);
      du += prod >>> 16;
    end
    // zero face change adds no constraint
    if (du != 0) begin
      umax = it.u0;
      umin = it.u0;
      if (it.nb) begin
        if (it.un > umax) umax = it.un;
        if (it.un < umin) umin = it.un;
      end
      if (du > 0) begin
        bound = umax - it.u0;
        r = (64'(bound) << 16) / 64'(du);
      end else begin
        bound = it.u0 - umin;
        r = (64'(bound) << 16) / 64'(-du);
      end
      phi = venkat_phi(r);
      if (phi < run_phi) run_phi = phi;
    end
    if (!it.side_last) return;
    phi_slot[it.k] = run_phi;
    for (int i = 0; i < 3; i++) grad_slot[it.k][i] = g[i];
    if (int'(it.k) + 1 > nstored) nstored = it.k + 1;
    run_phi = ONE_Q15;
    if (!it.var_last) return;
    n_cells++;
    // cap momentum factors by the depth factor
    if (couple_q && nstored >= 3) begin
      if (phi_slot[1] > phi_slot[0]) phi_slot[1] = phi_slot[0];
      if (phi_slot[2] > phi_slot[0]) phi_slot[2] = phi_slot[0];
    end
    for (int v = 0; v < nstored; v++) begin
      res.v = v;
      res.f = phi_slot[v];
      res.x = 32'((longint'(grad_slot[v][0]) * longint'(res.f)) >>> 15);
      res.y = 32'((longint'(grad_slot[v][1]) * longint'(res.f)) >>> 15);
      res.z = 32'((longint'(grad_slot[v][2]) * longint'(res.f)) >>> 15);
      res.last = (v + 1 == nstored);
      expected_grads.push_back(res);
    end
    nstored = 0;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: feed queued sides, random gap bursts, optional hold
  // ---------------------------------------------------------------------------
  bit quiet = 0;       // no idling on either side
  bit send_hold = 0;   // sender pauses
  int gap_cnt = 0;

  always @(posedge clk) begin
    bit busy;
    side_item_t it;
    if (rst_n) begin
      busy = in_valid;
      if (in_valid && !in_stall) begin
        it.k = in_var_index;       it.side_last = in_side_last;
        it.var_last = in_var_last; it.nb = in_has_neighbor;
        it.u0 = in_cell_avg;       it.un = in_neighbor_avg;
        it.gx = in_grad_x; it.gy = in_grad_y; it.gz = in_grad_z;
        it.ox = in_offset_x; it.oy = in_offset_y; it.oz = in_offset_z;
        predict_side(it);
        n_in++;
        busy = 0;
      end
      if (!busy) begin
        if (gap_cnt > 0) begin
          gap_cnt--;
        end else if (!send_hold && pending_sides.size() > 0) begin
          it = pending_sides.pop_front();
          in_var_index <= it.k;        in_side_last <= it.side_last;
          in_var_last <= it.var_last;  in_has_neighbor <= it.nb;
          in_cell_avg <= it.u0;        in_neighbor_avg <= it.un;
          in_grad_x <= it.gx; in_grad_y <= it.gy; in_grad_z <= it.gz;
          in_offset_x <= it.ox; in_offset_y <= it.oy; in_offset_z <= it.oz;
          busy = 1;
          if (!quiet && $urandom_range(0, 5) == 0) gap_cnt = $urandom_range(1, 7);
        end
      end
      in_valid <= busy;
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver stall: random bursts plus one long hold-off
  // ---------------------------------------------------------------------------
  bit hold_req = 0;
  bit hold_done = 0;
  int stall_cnt = 0;

  always @(posedge clk) begin
    if (rst_n) begin
      if (hold_req && !hold_done) begin
        hold_done <= 1'b1;
        stall_cnt <= HOLD_CYCLES;
        out_stall <= 1'b1;
      end else if (stall_cnt > 0) begin
        stall_cnt <= stall_cnt - 1;
        out_stall <= 1'b1;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        stall_cnt <= $urandom_range(0, 6);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: compare each result transfer with the oldest expectation
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    lim_grad_t e;
    if (rst_n && out_valid && !out_stall) begin
      n_out++;
      if (expected_grads.size() == 0) begin
        n_err++;
        if (n_err <= 10) $display("unexpected result var=%0d", out_var);
      end else begin
        e = expected_grads.pop_front();
        if (out_var !== e.v || out_lim_grad_x !== e.x || out_lim_grad_y !== e.y ||
            out_lim_grad_z !== e.z || out_limit_factor !== e.f || out_last !== e.last) begin
          n_err++;
          if (n_err <= 10)
            $display("mismatch exp v=%0d g=(%0d %0d %0d) f=%0d l=%0d got v=%0d g=(%0d %0d %0d) f=%0d l=%0d",
                     e.v, e.x, e.y, e.z, e.f, e.last, out_var, out_lim_grad_x,
                     out_lim_grad_y, out_lim_grad_z, out_limit_factor, out_last);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: cycles without any transfer
  // ---------------------------------------------------------------------------
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus construction
  // ---------------------------------------------------------------------------
  function automatic logic signed [31:0] rand_q16(int mode);
    logic signed [31:0] v;
    case (mode)
      0: v = $urandom;                                     // full range
      1: v = $urandom_range(0, 32'h0003_FFFF);             // magnitude below four
      default: v = $urandom_range(0, 32'h0000_FFFF);
    endcase
    if (mode != 0 && $urandom_range(0, 1)) v = -v;
    return v;
  endfunction

  function automatic void add_side(logic [2:0] k, logic sl, logic vl, logic nb,
                                   logic signed [31:0] u0, logic signed [31:0] un,
                                   logic signed [31:0] gx, logic signed [31:0] gy,
                                   logic signed [31:0] gz, logic signed [31:0] ox,
                                   logic signed [31:0] oy, logic signed [31:0] oz);
    side_item_t it;
    it = '{k, sl, vl, nb, u0, un, gx, gy, gz, ox, oy, oz};
    pending_sides.push_back(it);
  endfunction

  // Well-formed cells: every variable 0..nv-1 sent, in shuffled order.
  function automatic void add_cells(int n_items);
    int added, nv, nsides, mode;
    int order[$];
    logic signed [31:0] u0;
    added = 0;
    while (added < n_items) begin
      nv = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 8) : $urandom_range(1, 4);
      order.delete();
      for (int v = 0; v < nv; v++) order.push_back(v);
      order.shuffle();
      foreach (order[j]) begin
        nsides = $urandom_range(1, 3);
        for (int s = 0; s < nsides; s++) begin
          mode = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 2);
          u0 = rand_q16(mode);
          add_side(order[j], s == nsides - 1,
                   // var_last on a non-final side is noise the block ignores
                   (s == nsides - 1) ? (j == nv - 1) : ($urandom_range(0, 7) == 0),
                   $urandom_range(0, 5) != 0, u0,
                   mode == 0 ? 32'($urandom) : u0 + rand_q16(2),
                   rand_q16(mode), rand_q16(mode), rand_q16(mode),
                   ($urandom_range(0, 9) == 0) ? 32'sd0 : rand_q16(mode),
                   rand_q16(mode), rand_q16(mode));
          added++;
        end
      end
    end
  endfunction

  task automatic wait_drained();
    do @(negedge clk);
    while (pending_sides.size() != 0 || in_valid || expected_grads.size() != 0);
  endtask

  task automatic write_reg(logic idx, logic [31:0] data);
    wait_drained();
    // a side that completes no cell may still be in flight
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_index <= idx;
    cfg_data <= data;
    cfg_valid <= 1'b1;
    do @(negedge clk);
    while (!cfg_ready);
    @(posedge clk);
    if (idx == REG_BETA) beta_q = data;
    else couple_q = data[0];
    n_cfg++;
    cfg_valid <= 1'b0;
  endtask

  localparam logic signed [31:0] QMAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] QMIN = 32'sh8000_0000;
  localparam logic signed [31:0] Q1 = 32'sh0001_0000;

  initial begin
    for (int v = 0; v < NSLOT; v++) begin
      phi_slot[v] = '0;
      for (int i = 0; i < 3; i++) grad_slot[v][i] = '0;
    end
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // directed: one-variable cell with zero face change
    add_side(0, 1, 1, 1, Q1, 2 * Q1, QMAX, QMIN, Q1, 0, 0, 0);
    // three variables: large ratio, no neighbor, negative face change
    add_side(0, 0, 0, 1, 0, 4 * Q1, Q1, 0, 0, Q1, 0, 0);
    add_side(0, 1, 0, 1, Q1, Q1, Q1, Q1, 0, Q1, 0, 0);        // bound zero
    add_side(1, 1, 0, 0, 0, QMAX, Q1, Q1, Q1, Q1, Q1, Q1);    // no neighbor
    add_side(2, 0, 1, 1, 0, -Q1, -Q1, 0, 0, Q1, 0, 0);        // du < 0, r = 1
    add_side(2, 1, 1, 1, 0, -Q1 / 2, Q1, 0, 0, -Q1, 0, 0);    // ratio below one
    // eight variables with field extremes
    add_side(7, 1, 0, 1, QMAX, QMIN, QMAX, QMAX, QMAX, QMAX, QMAX, QMAX);
    add_side(6, 1, 0, 1, QMIN, QMAX, QMIN, QMIN, QMIN, QMIN, QMIN, QMIN);
    add_side(5, 1, 0, 1, QMIN, QMAX, QMAX, QMIN, QMAX, QMIN, QMAX, QMIN);
    add_side(4, 1, 0, 0, -1, 1, -1, -1, -1, 1, 1, 1);
    add_side(3, 1, 0, 1, 0, 3 * Q1, 2 * Q1, 0, 0, Q1, 0, 0);  // r of one and a half
    add_side(2, 1, 0, 1, 0, Q1, -Q1, 0, 0, -Q1, 0, 0);
    add_side(1, 1, 0, 1, 0, Q1 / 8, Q1, 0, 0, Q1, 0, 0);
    add_side(0, 1, 1, 1, 0, QMAX, Q1, Q1, Q1, 1, 1, 1);
    add_cells(90);

    write_reg(REG_BETA, 32'd0);
    write_reg(REG_COUPLE, 1'b0);
    add_cells(80);

    // long receiver hold-off while the sender keeps offering sides
    write_reg(REG_BETA, 32'hFFFF_FFFF);
    write_reg(REG_COUPLE, 1'b1);
    hold_req = 1;
    add_cells(80);

    // sender pause mid-stream until every expected result is back
    send_hold = 1;
    do @(negedge clk);
    while (in_valid || expected_grads.size() != 0);
    send_hold = 0;
    write_reg(REG_BETA, $urandom_range(0, 32'h0004_0000));
    add_cells(60);

    // closing stretch without idling
    wait_drained();
    quiet = 1;
    write_reg(REG_BETA, 32'd65536);
    add_cells(60);

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("covered %0d sides, %0d cells, %0d gradients, %0d register writes",
             n_in, n_cells, n_out, n_cfg);
    $display("mismatches: %0d, outstanding: %0d", n_err, expected_grads.size());
    if (n_err == 0 && expected_grads.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/vsl_pkg.sv
rtl/vsl_div.sv
rtl/venkat_slope_limiter.sv
sim/tb_top.sv
